### rtl/gdad_pkg.sv
// Package for the Gregorian date shifter: types, calendar constants and month lengths.
package gdad_pkg;

  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int CountW = 16;
  // Signed working day value: wide enough for 31 + 65535 and 1 - 65535.
  localparam int WorkW  = 18;
  // Year position inside the 400-year leap cycle.
  localparam int CycW   = 9;

  localparam logic [YearW-1:0]  YearMin   = 14'd1;
  localparam logic [YearW-1:0]  YearMax   = 14'd9999;
  localparam logic [YearW-1:0]  LeapCycle = 14'd400;
  localparam logic [CycW-1:0]   CycLast   = 9'd399;
  localparam logic [MonthW-1:0] MonthJan  = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb  = 4'd2;
  localparam logic [MonthW-1:0] MonthDec  = 4'd12;
  localparam logic [DayW-1:0]   DayLast   = 5'd31;

  localparam logic OpAdd = 1'b0;
  localparam logic OpSub = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_NORM = 4'b0100,
    S_WALK = 4'b1000
  } state_t;

  // Leap test from the position in the 400-year cycle.
  function automatic logic is_leap(input logic [CycW-1:0] cyc);
    logic century;
    century = (cyc == 9'd100) || (cyc == 9'd200) || (cyc == 9'd300);
    return (cyc[1:0] == 2'b00) && !century;
  endfunction

  // Length of a month; codes outside 1..12 give 31.
  function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] m,
                                              input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### rtl/gregorian_date_add_days.sv
// Gregorian date shifter: moves a date forward or back by a day count, one month a cycle.
//
// The block takes one date at a time and walks it month by month through a single
// shared add/compare unit. The start year is first reduced to its place in the 400-year
// leap cycle by repeated subtraction (0 to 24 steps); one step then normalizes the start
// date and applies the day count, and the months are walked after that (one month per
// cycle, at most about 2160 for a count of 65535), after which the result word sits in an
// output register. in_stall stays high while an item is in progress or a result word
// waits to be taken. Years are clamped to 1..9999; running past either end returns
// 9999-12-31 or 0001-01-01 with out_of_range set. Start fields out of range are clamped
// before the walk.
module gregorian_date_add_days
  import gdad_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              opcode,
  input  logic [YearW-1:0]  start_year,
  input  logic [MonthW-1:0] start_month,
  input  logic [DayW-1:0]   start_day,
  input  logic [CountW-1:0] day_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [YearW-1:0]  result_year,
  output logic [MonthW-1:0] result_month,
  output logic [DayW-1:0]   result_day,
  output logic              out_of_range
);

  state_t                   state;
  logic                     op;
  logic [YearW-1:0]         year;
  logic [MonthW-1:0]        month;
  logic [DayW-1:0]          day_in;
  logic [CountW-1:0]        count;
  logic [YearW-1:0]         rem;
  logic [CycW-1:0]          cyc;
  logic signed [WorkW-1:0]  day;

  logic                     leap;
  logic [DayW-1:0]          len_cur;
  logic [DayW-1:0]          len_prev;
  logic [DayW-1:0]          day_norm;
  logic signed [WorkW-1:0]  len_cur_s;
  logic [CycW-1:0]          cyc_inc;
  logic [CycW-1:0]          cyc_dec;

  assign in_stall = (state != S_IDLE) || out_valid;

  // Month lengths for the current and the previous month of the working year.
  always_comb begin
    leap      = is_leap(cyc);
    len_cur   = days_in(month, leap);
    len_prev  = (month == MonthJan) ? DayLast : days_in(month - 4'd1, leap);
    len_cur_s = $signed({{(WorkW-DayW){1'b0}}, len_cur});
    cyc_inc   = (cyc == CycLast) ? '0 : cyc + 9'd1;
    cyc_dec   = (cyc == '0) ? CycLast : cyc - 9'd1;
    if (day_in == '0) begin
      day_norm = 5'd1;
    end else if (day_in > len_cur) begin
      day_norm = len_cur;
    end else begin
      day_norm = day_in;
    end
  end

  // Sequencer and the shared month-step unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op     <= opcode;
            count  <= day_count;
            day_in <= start_day;
            if (start_year < YearMin) begin
              year <= YearMin;
              rem  <= YearMin;
            end else if (start_year > YearMax) begin
              year <= YearMax;
              rem  <= YearMax;
            end else begin
              year <= start_year;
              rem  <= start_year;
            end
            if (start_month < MonthJan) begin
              month <= MonthJan;
            end else if (start_month > MonthDec) begin
              month <= MonthDec;
            end else begin
              month <= start_month;
            end
            state <= S_MOD;
          end
        end
        S_MOD: begin
          // Reduce the year to its place in the leap cycle.
          if (rem >= LeapCycle) begin
            rem <= rem - LeapCycle;
          end else begin
            cyc   <= rem[CycW-1:0];
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (op == OpSub) begin
            day <= $signed({{(WorkW-DayW){1'b0}}, day_norm})
                 - $signed({{(WorkW-CountW){1'b0}}, count});
          end else begin
            day <= $signed({{(WorkW-DayW){1'b0}}, day_norm})
                 + $signed({{(WorkW-CountW){1'b0}}, count});
          end
          state <= S_WALK;
        end
        S_WALK: begin
          if (op == OpAdd) begin
            if (day > len_cur_s) begin
              day <= day - len_cur_s;
              if (month == MonthDec) begin
                if (year == YearMax) begin
                  result_year  <= YearMax;
                  result_month <= MonthDec;
                  result_day   <= DayLast;
                  out_of_range <= 1'b1;
                  out_valid    <= 1'b1;
                  state        <= S_IDLE;
                end else begin
                  year  <= year + 14'd1;
                  month <= MonthJan;
                  cyc   <= cyc_inc;
                end
              end else begin
                month <= month + 4'd1;
              end
            end else begin
              result_year  <= year;
              result_month <= month;
              result_day   <= day[DayW-1:0];
              out_of_range <= 1'b0;
              out_valid    <= 1'b1;
              state        <= S_IDLE;
            end
          end else begin
            if (day < $signed(18'sd1)) begin
              if (month == MonthJan) begin
                if (year == YearMin) begin
                  result_year  <= YearMin;
                  result_month <= MonthJan;
                  result_day   <= 5'd1;
                  out_of_range <= 1'b1;
                  out_valid    <= 1'b1;
                  state        <= S_IDLE;
                end else begin
                  // December is 31 days in every year.
                  year  <= year - 14'd1;
                  month <= MonthDec;
                  cyc   <= cyc_dec;
                  day   <= day + $signed({{(WorkW-DayW){1'b0}}, DayLast});
                end
              end else begin
                month <= month - 4'd1;
                day   <= day + $signed({{(WorkW-DayW){1'b0}}, len_prev});
              end
            end else begin
              result_year  <= year;
              result_month <= month;
              result_day   <= day[DayW-1:0];
              out_of_range <= 1'b0;
              out_valid    <= 1'b1;
              state        <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
